// ----- sv/hrpw_pkg.sv -----
// shared types and constants of the hex record page writer
`default_nettype none

package hrpw_pkg;

    // operation codes on the output side
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // record type that closes the image
    localparam logic [7:0] REC_END = 8'h01;

    // padding value for unused record slots
    localparam logic [7:0] PAD_BYTE = 8'hFF;

    // wide enough for the largest supported record slot count
    localparam int PAD_W = 7;

    // depth of the command queue between parser and expander
    localparam int QUEUE_DEPTH = 4;

    // one parsed command: address load, data write, padding run, finish
    typedef struct packed {
        logic             load;
        logic [13:0]      addr;
        logic             wr;
        logic [7:0]       data;
        logic [PAD_W-1:0] pad;
        logic             fin;
    } t_cmd;

endpackage

`default_nettype wire

// ----- sv/hex_record_page_writer.sv -----
// top level of the hex record to flash page writer
//
// slave stream: one byte of the binary hex image per word on s_axis_tdata.
// master stream: programming operations, one per word. tuser carries the
// operation (load page address, write byte, image finished), tdata the
// page address, data byte and page end flag, tlast marks the last word
// caused by one input byte.
// the parser writes the command for a byte into the queue when the byte is
// accepted; the expander then moves it into the output register.
// throughput: one output word per cycle while tready is high, set by the
// expander; input bytes are taken one per cycle while the four-entry
// command queue has room, so a padding run of a record stalls the input
// once the queue fills.
// reset clears the parser, the page counters, the queue and the output
// register; no output word is pending after reset.
// a stall on the master side holds the output register, then fills the
// queue and finally drops s_axis_tready; nothing is lost or repeated.
// after the end record the remaining image bytes are taken and ignored.
`default_nettype none

module hex_record_page_writer
    import hrpw_pkg::*;
#(
    parameter int PAGE_BYTES   = 32,
    parameter int RECORD_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // record_byte [7:0]
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata,   // page_address [13:0], prog_byte [21:14],
                                             // page_end_ack [22], zero [23]
    output      logic [1:0]  m_axis_tuser,   // op_kind [1:0]
    output      logic        m_axis_tlast    // last_of_run
);

    // parser to queue
    logic push;
    t_cmd push_cmd;
    logic q_full;

    // queue to expander
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    // expander outputs
    logic [13:0] out_addr;
    logic [7:0]  out_data;
    logic        out_ack;

    hrpw_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .RECORD_SLOTS (RECORD_SLOTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .o_ready  (s_axis_tready),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    hrpw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    hrpw_back #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (m_axis_tuser),
        .o_addr    (out_addr),
        .o_data    (out_data),
        .o_ack     (out_ack),
        .o_last    (m_axis_tlast)
    );

    // pack the output word, highest field first
    assign m_axis_tdata = {1'b0, out_ack, out_data, out_addr};

endmodule

`default_nettype wire

// ----- sv/hrpw_front.sv -----
// record parser: turns each image byte into at most one command
`default_nettype none

module hrpw_front
    import hrpw_pkg::*;
#(
    parameter int PAGE_BYTES   = 32,
    parameter int RECORD_SLOTS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    output      logic       o_ready,
    input  wire logic       i_q_full,
    output      logic       o_push,
    output      t_cmd       o_cmd
);

    localparam int POS_W = $clog2(PAGE_BYTES);
    localparam int SUM_W = $clog2(PAGE_BYTES + RECORD_SLOTS);
    localparam int WRAPS = (RECORD_SLOTS + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam logic [7:0] SLOTS8 = 8'(RECORD_SLOTS);
    localparam logic [SUM_W-1:0] PAGE_S = SUM_W'(PAGE_BYTES);

    logic [1:0]       r_field, n_field;
    logic             r_in_data, n_in_data;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_ahi, n_ahi;
    logic [7:0]       r_alo, n_alo;
    logic [7:0]       r_kind, n_kind;
    logic [7:0]       r_seen, n_seen;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_done, n_done;

    logic             accept;
    logic             page_open;
    logic [7:0]       lim;
    logic [SUM_W-1:0] sum;
    t_cmd             cmd;

    assign o_ready   = !i_q_full;
    assign accept    = i_valid && !i_q_full;
    assign page_open = (r_pos != '0);
    assign lim       = (r_len < SLOTS8) ? r_len : SLOTS8;

    always_comb begin
        n_field   = r_field;
        n_in_data = r_in_data;
        n_len     = r_len;
        n_ahi     = r_ahi;
        n_alo     = r_alo;
        n_kind    = r_kind;
        n_seen    = r_seen;
        n_done    = r_done;
        cmd       = '0;
        if (accept && !r_done) begin
            if (r_in_data) begin
                if (r_seen < r_len) begin
                    // first slots are written, surplus data dropped
                    cmd.wr   = (r_seen < SLOTS8);
                    cmd.data = (r_seen < SLOTS8) ? i_byte : 8'h00;
                    n_seen   = r_seen + 8'd1;
                    if (r_seen + 8'd1 == lim) begin
                        cmd.pad = PAD_W'(SLOTS8 - lim);
                    end
                end else begin
                    // checksum byte
                    n_in_data = 1'b0;
                    n_field   = 2'd0;
                    if (r_kind == REC_END && !page_open) begin
                        n_done  = 1'b1;
                        cmd.fin = 1'b1;
                    end
                end
            end else begin
                case (r_field)
                    2'd0: begin
                        n_len   = i_byte;
                        n_field = 2'd1;
                    end
                    2'd1: begin
                        n_ahi   = i_byte;
                        n_field = 2'd2;
                    end
                    2'd2: begin
                        n_alo   = i_byte;
                        n_field = 2'd3;
                    end
                    default: begin
                        n_kind  = i_byte;
                        n_field = 2'd0;
                        if (i_byte == REC_END && !page_open) begin
                            n_done  = 1'b1;
                            cmd.fin = 1'b1;
                        end else begin
                            if (!page_open) begin
                                cmd.load = 1'b1;
                                cmd.addr = {r_ahi, r_alo[7:2]};
                            end
                            n_in_data = 1'b1;
                            n_seen    = 8'd0;
                            if (r_len == 8'd0) begin
                                cmd.pad = PAD_W'(SLOTS8);
                            end
                        end
                    end
                endcase
            end
        end
    end

    // page position advances by the writes this byte causes
    always_comb begin
        sum = SUM_W'(r_pos) + SUM_W'(cmd.wr) + SUM_W'(cmd.pad);
        for (int i = 0; i < WRAPS; i++) begin
            if (sum >= PAGE_S) begin
                sum = sum - PAGE_S;
            end
        end
        n_pos = POS_W'(sum);
    end

    assign o_push = accept && (cmd.load || cmd.wr || (cmd.pad != '0) || cmd.fin);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field   <= 2'd0;
            r_in_data <= 1'b0;
            r_len     <= 8'd0;
            r_ahi     <= 8'd0;
            r_alo     <= 8'd0;
            r_kind    <= 8'd0;
            r_seen    <= 8'd0;
            r_pos     <= '0;
            r_done    <= 1'b0;
        end else begin
            r_field   <= n_field;
            r_in_data <= n_in_data;
            r_len     <= n_len;
            r_ahi     <= n_ahi;
            r_alo     <= n_alo;
            r_kind    <= n_kind;
            r_seen    <= n_seen;
            r_pos     <= n_pos;
            r_done    <= n_done;
        end
    end

endmodule

`default_nettype wire

// ----- sv/hrpw_queue.sv -----
// short command queue between parser and expander
`default_nettype none

module hrpw_queue
    import hrpw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output      logic o_full,
    input  wire logic i_pop,
    output      logic o_valid,
    output      t_cmd o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/hrpw_back.sv -----
// command expander: one output word per cycle into an output register unless i_ready stalls it
`default_nettype none

module hrpw_back
    import hrpw_pkg::*;
#(
    parameter int PAGE_BYTES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_cmd        i_q_cmd,
    output      logic        o_pop,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [1:0]  o_kind,
    output      logic [13:0] o_addr,
    output      logic [7:0]  o_data,
    output      logic        o_ack,
    output      logic        o_last
);

    localparam int BPOS_W = $clog2(PAGE_BYTES);
    localparam logic [BPOS_W-1:0] POS_LAST = BPOS_W'(PAGE_BYTES - 1);

    logic              r_busy;
    t_cmd              r_cur;
    logic [BPOS_W-1:0] r_bpos;
    logic              r_valid;
    logic [1:0]        r_kind;
    logic [13:0]       r_addr;
    logic [7:0]        r_data;
    logic              r_ack;
    logic              r_last;

    logic              advance;
    logic              src_valid;
    t_cmd              src, rem;
    logic              rem_empty;
    logic              is_write;
    logic [1:0]        n_kind;
    logic [13:0]       n_addr;
    logic [7:0]        n_data;

    assign advance   = !r_valid || i_ready;
    assign src       = r_busy ? r_cur : i_q_cmd;
    assign src_valid = r_busy || i_q_valid;
    assign o_pop     = advance && !r_busy && i_q_valid;

    // take the first pending part of the command, in load, write, pad, finish order
    always_comb begin
        rem      = src;
        is_write = 1'b0;
        n_kind   = OP_FINISH;
        n_addr   = 14'd0;
        n_data   = 8'd0;
        if (src.load) begin
            rem.load = 1'b0;
            n_kind   = OP_LOAD;
            n_addr   = src.addr;
        end else if (src.wr) begin
            rem.wr   = 1'b0;
            is_write = 1'b1;
            n_kind   = OP_WRITE;
            n_data   = src.data;
        end else if (src.pad != '0) begin
            rem.pad  = src.pad - 1'b1;
            is_write = 1'b1;
            n_kind   = OP_WRITE;
            n_data   = PAD_BYTE;
        end else begin
            rem.fin  = 1'b0;
        end
        rem_empty = !rem.load && !rem.wr && (rem.pad == '0) && !rem.fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_bpos  <= '0;
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= src_valid;
            if (src_valid) begin
                r_busy <= !rem_empty;
                r_cur  <= rem;
                r_kind <= n_kind;
                r_addr <= n_addr;
                r_data <= n_data;
                r_ack  <= is_write && (r_bpos == POS_LAST);
                r_last <= rem_empty;
                if (is_write) begin
                    r_bpos <= (r_bpos == POS_LAST) ? '0 : r_bpos + 1'b1;
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_addr  = r_addr;
    assign o_data  = r_data;
    assign o_ack   = r_ack;
    assign o_last  = r_last;

endmodule

`default_nettype wire
